@@ hw/rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	// Build defaults
	localparam int DEPTH_DEF      = 16;
	localparam int PRIO_WIDTH_DEF = 8;

	// Field widths on the ports
	localparam int BYTE_W      = 8;
	localparam int CAP_W       = 5;
	localparam int COUNT_W     = 5;
	localparam int STATUS_W    = 2;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 24;
	localparam int CAP_RESET   = 16;

	// Operation codes carried on the input tuser
	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	// Result status carried on the output tuser
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

@@ hw/rtl/sorted_priority_queue.sv @@
// Sorted priority queue: circular entry memory with tail-side insertion sort.
// A rejected enqueue, an empty dequeue and an enqueue into an empty queue give their result directly;
// a dequeue first reads the head entry from the synchronous memory.
// An enqueue into a non-empty queue moves each entry with a larger priority up one place,
// one memory read and one write per step, and then writes the new entry.
// One item is in work at a time; the result register frees the input once it is taken.
// arst_n clears the count, head pointer and result valid, and sets capacity to 16.
module sorted_priority_queue #(
	parameter int DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [spq_pkg::CAP_W-1:0]      cfg_wdata,     // capacity
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [spq_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // item_prio[7:0], item_info[15:8]
	input  logic                           s_axis_tuser,  // kind
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [spq_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // out_prio[7:0], out_info[15:8],
	                                                      // count[20:16], zero[23:21]
	output logic [spq_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);
	import spq_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	typedef struct packed {
		logic [PRIO_WIDTH-1:0] prio;
		logic [BYTE_W-1:0]     info;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEQ,
		S_INS,
		S_PUT
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CW-1:0]       fill_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       pos_q;
	entry_t              new_q;

	entry_t              mem_q [DEPTH];
	entry_t              rd_data_q;

	logic                m_valid_q;
	status_t             out_status_q;
	logic [BYTE_W-1:0]   out_prio_q;
	logic [BYTE_W-1:0]   out_info_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic                in_beat;
	logic                full;
	logic                larger;
	logic                res_load;
	entry_t              in_entry;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	entry_t              mem_wdata;
	logic [AW-1:0]       mem_raddr;
	logic [CW-1:0]       fill_inc;
	logic [CW-1:0]       fill_dec;

	// Map a queue position to a memory address relative to the head
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] lidx);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, lidx};
		if (sum >= (AW + 1)'(DEPTH)) begin
			sum = sum - (AW + 1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	assign in_entry.prio = PRIO_WIDTH'(s_axis_tdata[BYTE_W-1:0]);
	assign in_entry.info = s_axis_tdata[2*BYTE_W-1:BYTE_W];

	// Full when the count reaches the capacity or the built depth
	assign full = (CMPW'(fill_q) >= CMPW'(cap_q)) || (fill_q == CW'(DEPTH));

	assign larger   = rd_data_q.prio > new_q.prio;
	assign fill_inc = fill_q + CW'(1);
	assign fill_dec = fill_q - CW'(1);

	// Load a result beat in this cycle
	assign res_load = (state_q == S_DEQ) || (state_q == S_PUT) || (state_q == S_INS && !larger)
		|| (state_q == S_IDLE && in_beat
			&& (fill_q == '0 || (s_axis_tuser == KIND_ENQ && full)));

	// Steer the memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = phys(head_q, pos_q);
		mem_wdata = new_q;
		mem_raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_beat && s_axis_tuser == KIND_ENQ && !full) begin
					if (fill_q == '0) begin
						mem_we    = 1'b1;
						mem_waddr = head_q;
						mem_wdata = in_entry;
					end else begin
						mem_raddr = phys(head_q, AW'(fill_dec));
					end
				end
			end
			S_INS: begin
				mem_we = 1'b1;
				if (larger) begin
					mem_wdata = rd_data_q;
					mem_raddr = phys(head_q, pos_q - AW'(2));
				end
			end
			S_PUT: begin
				mem_we = 1'b1;
			end
			S_DEQ: begin
			end
			default: begin
			end
		endcase
	end

	// Entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem_q[mem_raddr];
	end

	// Sequence the operation and hold the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cap_q        <= CAP_W'(CAP_RESET);
			fill_q       <= '0;
			head_q       <= '0;
			pos_q        <= '0;
			new_q        <= '0;
			m_valid_q    <= 1'b0;
			out_status_q <= ST_DONE;
			out_prio_q   <= '0;
			out_info_q   <= '0;
			out_count_q  <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (m_axis_tready && !res_load) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						out_prio_q <= '0;
						out_info_q <= '0;
						new_q      <= in_entry;
						pos_q      <= AW'(fill_q);
						if (s_axis_tuser == KIND_ENQ) begin
							if (full) begin
								m_valid_q    <= 1'b1;
								out_status_q <= ST_FULL;
								out_count_q  <= COUNT_W'(fill_q);
							end else if (fill_q == '0) begin
								m_valid_q    <= 1'b1;
								out_status_q <= ST_DONE;
								out_count_q  <= COUNT_W'(fill_inc);
								fill_q       <= fill_inc;
							end else begin
								state_q <= S_INS;
							end
						end else begin
							if (fill_q == '0) begin
								m_valid_q    <= 1'b1;
								out_status_q <= ST_EMPTY;
								out_count_q  <= '0;
							end else begin
								state_q <= S_DEQ;
							end
						end
					end
				end
				S_DEQ: begin
					m_valid_q    <= 1'b1;
					out_status_q <= ST_DONE;
					out_prio_q   <= BYTE_W'(rd_data_q.prio);
					out_info_q   <= rd_data_q.info;
					out_count_q  <= COUNT_W'(fill_dec);
					fill_q       <= fill_dec;
					head_q       <= phys(head_q, AW'(1));
					state_q      <= S_IDLE;
				end
				S_INS: begin
					if (larger) begin
						// shift the stored entry up one place and move down
						pos_q <= pos_q - AW'(1);
						if (pos_q == AW'(1)) begin
							state_q <= S_PUT;
						end
					end else begin
						m_valid_q    <= 1'b1;
						out_status_q <= ST_DONE;
						out_count_q  <= COUNT_W'(fill_inc);
						fill_q       <= fill_inc;
						state_q      <= S_IDLE;
					end
				end
				S_PUT: begin
					m_valid_q    <= 1'b1;
					out_status_q <= ST_DONE;
					out_count_q  <= COUNT_W'(fill_inc);
					fill_q       <= fill_inc;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(M_TDATA_W - COUNT_W - 2*BYTE_W)'(0), out_count_q, out_info_q,
		out_prio_q};
	assign m_axis_tuser  = out_status_q;

endmodule

@@ hw/rtl/spq_props.sv @@
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_props (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [spq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic [spq_pkg::STATUS_W-1:0]   m_axis_tuser
);
	import spq_pkg::*;

	// Hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// Never take an item while a stalled result blocks the output register
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid && !m_axis_tready))
		else $error("input taken with output register blocked");

	// Rejected or empty results carry no entry
	a_zero_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_EMPTY) |->
			m_axis_tdata[2*BYTE_W-1:0] == '0)
		else $error("non-done result carries entry data");

	// An empty dequeue reports a zero count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_EMPTY |->
			m_axis_tdata[2*BYTE_W+COUNT_W-1:2*BYTE_W] == '0)
		else $error("empty status with nonzero count");

endmodule

bind sorted_priority_queue spq_props u_spq_props (.*);

@@ tb/sorted_priority_queue_tb.sv @@
// Self-checking stream testbench for the sorted priority queue, with its own queue predictor.
module sorted_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = DEPTH + 4;

	typedef struct packed {
		logic             kind;
		logic [BYTE_W-1:0] prio;
		logic [BYTE_W-1:0] info;
	} queue_op_t;

	typedef struct packed {
		status_t            status;
		logic [BYTE_W-1:0]  prio;
		logic [BYTE_W-1:0]  info;
		logic [COUNT_W-1:0] count;
	} queue_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CAP_W-1:0]     cfg_wdata = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // item_prio[7:0], item_info[15:8]
	logic                 s_axis_tuser = 1'b0; // kind
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;        // out_prio[7:0], out_info[15:8], count[20:16]
	logic [STATUS_W-1:0]  m_axis_tuser;        // status

	// Predictor state: sorted entries, fill level and capacity
	logic [BYTE_W-1:0]  sorted_prio [DEPTH];
	logic [BYTE_W-1:0]  sorted_info [DEPTH];
	int                 fill_level = 0;
	int                 cap_model = CAP_RESET;

	queue_op_t  pending_ops[$];
	queue_res_t expected_results[$];
	logic       beat_taken = 1'b0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         errors = 0;
	int         cycle_cnt = 0;

	sorted_priority_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one queue operation to the predictor and return its result
	function automatic queue_res_t apply_queue_op(queue_op_t op);
		queue_res_t res;
		int eff_cap;
		int pos;
		res.status = ST_DONE;
		res.prio = '0;
		res.info = '0;
		eff_cap = (cap_model > DEPTH) ? DEPTH : cap_model;
		if (op.kind == KIND_ENQ) begin
			if (fill_level >= eff_cap) begin
				res.status = ST_FULL;
			end else begin
				// insert behind every entry of lower or equal priority
				pos = 0;
				while (pos < fill_level && sorted_prio[pos] <= op.prio)
					pos++;
				for (int i = fill_level; i > pos; i--) begin
					sorted_prio[i] = sorted_prio[i-1];
					sorted_info[i] = sorted_info[i-1];
				end
				sorted_prio[pos] = op.prio;
				sorted_info[pos] = op.info;
				fill_level++;
			end
		end else begin
			if (fill_level == 0) begin
				res.status = ST_EMPTY;
			end else begin
				// pop the head and shift the rest forward
				res.prio = sorted_prio[0];
				res.info = sorted_info[0];
				for (int i = 1; i < fill_level; i++) begin
					sorted_prio[i-1] = sorted_prio[i];
					sorted_info[i-1] = sorted_info[i];
				end
				fill_level--;
			end
		end
		res.count = COUNT_W'(fill_level);
		return res;
	endfunction

	function automatic queue_op_t make_op(logic kind, int prio, int info);
		queue_op_t op;
		op.kind = kind;
		op.prio = BYTE_W'(prio);
		op.info = BYTE_W'(info);
		return op;
	endfunction

	// Random operation: enqueue share in percent, priorities biased toward ties and extremes
	function automatic queue_op_t random_op(int enq_pct);
		queue_op_t op;
		int sel;
		op.kind = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
		sel = $urandom_range(3);
		if (sel == 0)
			op.prio = BYTE_W'($urandom_range(3));
		else if (sel == 1)
			op.prio = $urandom_range(1) ? 8'hff : 8'h00;
		else
			op.prio = BYTE_W'($urandom_range(255));
		op.info = BYTE_W'($urandom_range(255));
		return op;
	endfunction

	// Wait until every item is taken and every result has come back
	task automatic wait_idle();
		do begin
			@(negedge clk);
			#1;
		end while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
	endtask

	task automatic write_capacity(int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CAP_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: present the next pending beat at the falling edge
	always @(negedge clk) begin : driver
		queue_op_t nxt;
		if (!s_axis_tvalid || beat_taken) begin
			if (arst_n && pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_ops.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {nxt.info, nxt.prio};
				s_axis_tuser <= nxt.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: check result beats, predict accepted input beats, track capacity writes
	always @(posedge clk) begin : monitor
		queue_op_t  op;
		queue_res_t want;
		queue_res_t got;
		if (arst_n) begin
			if (cfg_we)
				cap_model = int'(cfg_wdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tuser);
				got.prio = m_axis_tdata[7:0];
				got.info = m_axis_tdata[15:8];
				got.count = m_axis_tdata[20:16];
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat status %0d prio %0d info %0d count %0d",
						$time, got.status, got.prio, got.info, got.count);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.prio !== want.prio ||
					    got.info !== want.info || got.count !== want.count ||
					    m_axis_tdata[23:21] !== 3'b000) begin
						errors++;
						$display({"%0t: mismatch expected status %0d prio %0d info %0d count %0d",
							" pad 0, actual status %0d prio %0d info %0d count %0d pad %0d"},
							$time, want.status, want.prio, want.info, want.count,
							m_axis_tuser, got.prio, got.info, got.count, m_axis_tdata[23:21]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				op.kind = s_axis_tuser;
				op.prio = s_axis_tdata[7:0];
				op.info = s_axis_tdata[15:8];
				expected_results.push_back(apply_queue_op(op));
			end
		end
		beat_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int cap_val;
		int enq_pct;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pop, extremes, ties in arrival order, middle insert, drain to empty
		pending_ops.push_back(make_op(KIND_DEQ, 8'hff, 8'hff));
		pending_ops.push_back(make_op(KIND_ENQ, 255, 8'hff));
		pending_ops.push_back(make_op(KIND_ENQ, 0, 8'h00));
		pending_ops.push_back(make_op(KIND_ENQ, 7, 8'h61));
		pending_ops.push_back(make_op(KIND_ENQ, 7, 8'h62));
		pending_ops.push_back(make_op(KIND_ENQ, 128, 8'h55));
		pending_ops.push_back(make_op(KIND_ENQ, 7, 8'h63));
		pending_ops.push_back(make_op(KIND_ENQ, 0, 8'haa));
		pending_ops.push_back(make_op(KIND_ENQ, 255, 8'h00));
		for (int i = 0; i < 10; i++)
			pending_ops.push_back(make_op(KIND_DEQ, 8'h00, 8'h00));
		wait_idle();

		// Random phases, each with its own capacity and one of four idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: cap_val = 16;
				1: cap_val = 3;
				2: cap_val = 0;
				3: cap_val = 31;
				4: cap_val = 1;
				5: cap_val = 17;
				6: cap_val = 2;
				default: cap_val = 9;
			endcase
			repeat (DRAIN_WAIT) @(posedge clk);
			write_capacity(cap_val);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 71;
				end
				default: begin
					send_idle_pct = 24;
					recv_stall_pct = 24;
				end
			endcase
			for (int ch = 0; ch < 7; ch++) begin
				// last chunk fills up so the next capacity may land below the count
				if (ch == 6) begin
					enq_pct = 85;
				end else begin
					case ($urandom_range(4))
						0: enq_pct = 20;
						1: enq_pct = 50;
						2: enq_pct = 65;
						3: enq_pct = 85;
						default: enq_pct = 95;
					endcase
				end
				for (int n = 0; n < 30; n++)
					pending_ops.push_back(random_op(enq_pct));
				// hold the sender once until the queue output has caught up
				if (ph == 4 && ch == 3)
					wait_idle();
			end
			wait_idle();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
